// File: sv/bbf_pkg.sv
// Shared types and constants for the bit string forwarding engine.
// No dependencies; every other file imports this package.
package bbf_pkg;

   localparam int BITS_W = 64;
   localparam int IDX_W  = 6;
   localparam int ENT_W  = 20;
   localparam int CFG_W  = 7;

   localparam logic CSR_LOCAL_ID     = 1'b0;
   localparam logic CSR_ROUTER_COUNT = 1'b1;

   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_FORWARD = 1'b1;

   typedef enum logic [1:0] {
      KIND_FWD   = 2'd0,
      KIND_LOCAL = 2'd1,
      KIND_ERR   = 2'd2
   } kind_type;

   typedef struct packed {
      logic              mode;
      logic [IDX_W-1:0]  entry_index;
      logic              path_slot;
      logic              two_paths;
      logic [BITS_W-1:0] forward_mask;
      logic [BITS_W-1:0] packet_bits;
      logic [ENT_W-1:0]  entropy;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  router_index;
      logic              chosen_slot;
      logic [BITS_W-1:0] copy_bits;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             addr;
      logic [CFG_W-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [CFG_W-1:0] local_id;
      logic [CFG_W-1:0] router_count;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  entry;
      logic              slot;
      logic              two_paths;
      logic [BITS_W-1:0] mask;
   } tbl_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] entry;
      logic             local_sel;
      logic             pick;
   } tbl_rd_type;

   typedef struct packed {
      logic [BITS_W-1:0] mask;
      logic              slot;
   } tbl_dat_type;

endpackage

// File: sv/bbf_intf.sv
// Valid/ready channel interfaces for request, response and CSR beats.
// Depends on bbf_pkg for the payload types.
interface bbf_req_if import bbf_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bbf_rsp_if import bbf_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bbf_csr_if import bbf_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/bbf_table.sv
// Forwarding mask memory (one entry per router and path) and two-path flags.
// Depends on bbf_pkg; read data is registered.
module bbf_table import bbf_pkg::*; #(
   parameter int MAX_ROUTERS = 64,
   parameter int PATH_WAYS   = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  tbl_wr_type  wr,
   input  tbl_rd_type  rd,
   output tbl_dat_type dat
);

   localparam int DEPTH = MAX_ROUTERS * PATH_WAYS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;

   logic [BITS_W-1:0]      mem [DEPTH];
   logic [MAX_ROUTERS-1:0] flags_ff;
   logic [MAX_ROUTERS-1:0] flags_in;
   logic [BITS_W-1:0]      rd_mask_ff;
   logic                   rd_slot_ff;
   logic                   wr_ok;
   logic [AW-1:0]          waddr;
   logic [AW-1:0]          raddr;
   logic                   rd_slot;

   always_comb begin
      wr_ok = wr.en && ({1'b0, wr.entry} < (IDX_W+1)'(MAX_ROUTERS))
            && ({1'b0, wr.slot} < 2'(PATH_WAYS));
      waddr = AW'(int'(wr.entry) * PATH_WAYS + int'(wr.slot));
      rd_slot = (PATH_WAYS > 1) && !rd.local_sel && flags_ff[rd.entry[RW-1:0]] && rd.pick;
      raddr = AW'(int'(rd.entry) * PATH_WAYS + int'(rd_slot));
      flags_in = flags_ff;
      if (wr_ok) begin
         flags_in[wr.entry[RW-1:0]] = wr.two_paths;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[waddr] <= wr.mask;
      end
      if (rd.en) begin
         rd_mask_ff <= mem[raddr];
         rd_slot_ff <= rd_slot;
      end
   end

   assign dat.mask = rd_mask_ff;
   assign dat.slot = rd_slot_ff;

endmodule

// File: sv/bbf_scan.sv
// Bit scan sequencer: walks the packet bit string, reads the table per mapped
// set bit and loads the response register. Depends on bbf_pkg and bbf_intf.
module bbf_scan import bbf_pkg::*; #(
   parameter int MAX_ROUTERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   bbf_req_if.sink     req_if,
   bbf_rsp_if.source   rsp_if,
   input  cfg_type     cfg,
   output tbl_wr_type  tbl_wr,
   output tbl_rd_type  tbl_rd,
   input  tbl_dat_type tbl_dat
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              pick_ff, pick_in;
   kind_type          kind_ff, kind_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [IDX_W:0]    idx_ext;
   logic              is_err;
   logic              is_local;
   logic              rsp_free;
   logic              at_end;
   logic [BITS_W-1:0] new_bits;
   logic [BITS_W-1:0] above;
   logic              done;

   always_comb begin
      idx_ext  = {1'b0, idx_ff};
      is_err   = (idx_ext >= cfg.router_count) || (idx_ext >= (IDX_W+1)'(MAX_ROUTERS));
      is_local = (cfg.local_id != '0) && (idx_ext == cfg.local_id - CFG_W'(1));
      rsp_free = !rsp_valid_ff || rsp_if.ready;
      at_end   = (idx_ff == IDX_W'(BITS_W - 1));
      new_bits = bits_ff & ~tbl_dat.mask;
      above    = ({BITS_W{1'b1}} << idx_ff) << 1;
      done     = (new_bits & above) == '0;

      state_in     = state_ff;
      bits_in      = bits_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      tbl_wr       = '0;
      tbl_rd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.data.mode == MODE_WRITE) begin
                  tbl_wr.en        = 1'b1;
                  tbl_wr.entry     = req_if.data.entry_index;
                  tbl_wr.slot      = req_if.data.path_slot;
                  tbl_wr.two_paths = req_if.data.two_paths;
                  tbl_wr.mask      = req_if.data.forward_mask;
               end else begin
                  bits_in  = req_if.data.packet_bits;
                  pick_in  = req_if.data.entropy[0];
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (bits_ff[idx_ff]) begin
               if (is_err) begin
                  kind_in = KIND_ERR;
               end else begin
                  tbl_rd.en        = 1'b1;
                  tbl_rd.entry     = idx_ff;
                  tbl_rd.local_sel = is_local;
                  tbl_rd.pick      = pick_ff;
                  kind_in          = is_local ? KIND_LOCAL : KIND_FWD;
               end
               state_in = ST_EMIT;
            end else if (at_end) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.router_index = idx_ff;
               rsp_data_in.kind         = kind_ff;
               rsp_data_in.chosen_slot  = 1'b0;
               rsp_data_in.copy_bits    = '0;
               if (kind_ff == KIND_ERR) begin
                  rsp_data_in.last = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  if (kind_ff == KIND_FWD) begin
                     rsp_data_in.chosen_slot = tbl_dat.slot;
                     rsp_data_in.copy_bits   = bits_ff & tbl_dat.mask;
                  end
                  rsp_data_in.last = done;
                  bits_in          = new_bits;
                  if (done) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      idx_ff      <= idx_in;
      pick_ff     <= pick_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

// File: sv/bier_bitstring_forward_top.sv
// Top level of the bit string forwarding engine: CSRs, scan sequencer, table.
// Depends on bbf_pkg, bbf_intf, bbf_table and bbf_scan.
//
// Usage:
//   req_if: one beat is either a table write (mode 0: entry_index, path_slot,
//     two_paths, forward_mask) or a packet (mode 1: packet_bits, entropy).
//   rsp_if: one beat per handled set bit (forwarded copy, local delivery or
//     unmapped bit error); last marks the final beat of a packet. A packet
//     with an empty bit string gives no beat.
//   csr_if: addr 0 local_router_id, addr 1 router_count; always ready.
//     Write only while no packet is in flight.
// Sequence: a table write is taken in the idle state. A packet is taken in the
//   idle state, then scans the bit positions in order up to its last handled
//   bit (all 64 when none is handled), with an emit state for each result.
//   The one table read port and the scan of one bit position per cycle, paused
//   in each emit state, set this pace.
//   req_if is not ready while a packet is scanned.
// Stall: a held response beat holds the next emit cycle until it is taken.
// Reset: local_router_id 1, router_count 64, two-path flags cleared; table
//   entries are undefined until written.
module bier_bitstring_forward_top import bbf_pkg::*; #(
   parameter int MAX_ROUTERS = 64,
   parameter int PATH_WAYS   = 2
) (
   input logic       clock,
   input logic       reset,
   bbf_csr_if.sink   csr_if,
   bbf_req_if.sink   req_if,
   bbf_rsp_if.source rsp_if
);

   logic [CFG_W-1:0] local_id_ff, local_id_in;
   logic [CFG_W-1:0] count_ff, count_in;
   cfg_type          cfg;
   tbl_wr_type       tbl_wr;
   tbl_rd_type       tbl_rd;
   tbl_dat_type      tbl_dat;

   always_comb begin
      local_id_in = local_id_ff;
      count_in    = count_ff;
      if (csr_if.valid) begin
         unique case (csr_if.data.addr)
            CSR_LOCAL_ID:     local_id_in = csr_if.data.wdata;
            CSR_ROUTER_COUNT: count_in    = csr_if.data.wdata;
            default: begin
               local_id_in = local_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= CFG_W'(1);
         count_ff    <= CFG_W'(64);
      end else begin
         local_id_ff <= local_id_in;
         count_ff    <= count_in;
      end
   end

   assign csr_if.ready     = 1'b1;
   assign cfg.local_id     = local_id_ff;
   assign cfg.router_count = count_ff;

   bbf_scan #(
      .MAX_ROUTERS (MAX_ROUTERS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .cfg     (cfg),
      .tbl_wr  (tbl_wr),
      .tbl_rd  (tbl_rd),
      .tbl_dat (tbl_dat)
   );

   bbf_table #(
      .MAX_ROUTERS (MAX_ROUTERS),
      .PATH_WAYS   (PATH_WAYS)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .wr    (tbl_wr),
      .rd    (tbl_rd),
      .dat   (tbl_dat)
   );

endmodule
